FILE: design/rv2e_pkg.sv
// Shared types, constants and helper functions for the rotation vector to Euler core.
// No dependencies; each design file but rv2e_delay refers to it by scoped names.
`default_nettype none

package rv2e_pkg;

  localparam int unsigned CW       = 32;  // CORDIC datapath width, Q.24
  localparam int unsigned TAB_LEN  = 24;
  localparam int unsigned DIV_BITS = 28;  // quotient bits of the axis divider
  localparam int unsigned DEN_W    = 28;
  localparam int unsigned REM_W    = DEN_W + 1;
  localparam int unsigned NUM_W    = 51;

  localparam logic signed [CW-1:0] PI24      = 32'sd52707179;
  localparam logic signed [CW-1:0] TWO_PI24  = 32'sd105414358;
  localparam logic signed [CW-1:0] HALF_PI24 = 32'sd26353589;
  localparam logic signed [CW-1:0] ONE24     = 32'sd16777216;
  localparam logic signed [CW-1:0] KINV      = 32'sd10188014;

  localparam logic signed [15:0] ANG_LIM   = 16'sd25736;
  localparam logic signed [15:0] PITCH_LIM = 16'sd12868;
  localparam logic signed [33:0] Q14_LIM   = 34'sd16384;
  localparam logic signed [CW-1:0] SY_LIM  = 32'sd32768;

  localparam logic signed [CW-1:0] ATAN_TAB [TAB_LEN] = '{
    32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331,
    32'sd1047214,  32'sd524117,  32'sd262123,  32'sd131069,
    32'sd65536,    32'sd32768,   32'sd16384,   32'sd8192,
    32'sd4096,     32'sd2048,    32'sd1024,    32'sd512,
    32'sd256,      32'sd128,     32'sd64,      32'sd32,
    32'sd16,       32'sd8,       32'sd4,       32'sd2
  };

  // One divider lane: partial remainder, numerator, quotient so far
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [NUM_W-1:0]    num;
    logic [DIV_BITS-1:0] q;
  } div_lane_t;

  // Remove the CORDIC gain, round half up
  function automatic logic signed [CW-1:0] gain_fn(input logic signed [CW-1:0] x);
    logic signed [56:0] p;
    p = x * KINV + 57'sd8388608;
    return p[55:24];
  endfunction

  // Q.24 to Q1.14, round half up, saturate
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd512) >>> 10;
    if (r > Q14_LIM) r = Q14_LIM;
    else if (r < -Q14_LIM) r = -Q14_LIM;
    return r[15:0];
  endfunction

  // Q.24 angle to Q2.13, round half up, saturate to +-lim
  function automatic logic signed [15:0] to_q13(input logic signed [CW-1:0] a,
                                               input logic signed [15:0] lim);
    logic signed [CW-1:0] r;
    r = (a + 32'sd1024) >>> 11;
    if (r > lim) r = CW'(lim);
    else if (r < -lim) r = -CW'(lim);
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/rv2e_cordic_cell.sv
// One CORDIC micro-rotation stage, vectoring or rotation mode.
// Depends on rv2e_pkg for the datapath width and the arctangent table.
`default_nettype none

module rv2e_cordic_cell #(
  parameter int unsigned STEP = 0,
  parameter bit          VEC  = 1'b1
) (
  input  wire logic                          clk_i,
  input  wire logic signed [rv2e_pkg::CW-1:0] x_i,
  input  wire logic signed [rv2e_pkg::CW-1:0] y_i,
  input  wire logic signed [rv2e_pkg::CW-1:0] z_i,
  input  wire logic                          flag_i,
  output logic signed [rv2e_pkg::CW-1:0]      x_o,
  output logic signed [rv2e_pkg::CW-1:0]      y_o,
  output logic signed [rv2e_pkg::CW-1:0]      z_o,
  output logic                               flag_o
);

  localparam logic signed [rv2e_pkg::CW-1:0] ATAN = rv2e_pkg::ATAN_TAB[STEP];

  logic signed [rv2e_pkg::CW-1:0] xs, ys, x_d, y_d, z_d;
  logic                           pos;

  always_comb begin
    xs  = x_i >>> STEP;
    ys  = y_i >>> STEP;
    // vectoring drives y to zero, rotation drives z to zero
    pos = VEC ? y_i[rv2e_pkg::CW-1] : ~z_i[rv2e_pkg::CW-1];
    if (pos) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    z_o    <= z_d;
    flag_o <= flag_i;
  end

endmodule

`default_nettype wire

FILE: design/rv2e_cordic_chain.sv
// CORDIC chain: range pre-stage followed by a row of rv2e_cordic_cell stages.
// Depends on rv2e_pkg and rv2e_cordic_cell. Pre-stage and cells are all registered.
`default_nettype none

module rv2e_cordic_chain #(
  parameter int unsigned STEPS = 16,
  parameter bit          VEC   = 1'b1
) (
  input  wire logic                          clk_i,
  input  wire logic signed [rv2e_pkg::CW-1:0] x_i,
  input  wire logic signed [rv2e_pkg::CW-1:0] y_i,
  input  wire logic signed [rv2e_pkg::CW-1:0] z_i,
  output logic signed [rv2e_pkg::CW-1:0]      x_o,
  output logic signed [rv2e_pkg::CW-1:0]      y_o,
  output logic signed [rv2e_pkg::CW-1:0]      z_o
);

  logic signed [rv2e_pkg::CW-1:0] x_d, y_d, z_d;
  logic                           flag_d;
  logic signed [rv2e_pkg::CW-1:0] xc [STEPS+1];
  logic signed [rv2e_pkg::CW-1:0] yc [STEPS+1];
  logic signed [rv2e_pkg::CW-1:0] zc [STEPS+1];
  logic                           fc [STEPS+1];

  generate
    if (VEC) begin : g_vec_pre
      // flag marks the all-zero vector; fold the left half plane over by pi
      always_comb begin
        flag_d = (x_i == '0) && (y_i == '0);
        if (x_i[rv2e_pkg::CW-1]) begin
          x_d = -x_i;
          y_d = -y_i;
          z_d = z_i + (y_i[rv2e_pkg::CW-1] ? -rv2e_pkg::PI24 : rv2e_pkg::PI24);
        end else begin
          x_d = x_i;
          y_d = y_i;
          z_d = z_i;
        end
      end
    end else begin : g_rot_pre
      // wrap into [-pi, pi], then fold into [-pi/2, pi/2]; flag negates the result
      logic signed [rv2e_pkg::CW-1:0] a;
      always_comb begin
        a = z_i;
        if (a > rv2e_pkg::PI24) a = a - rv2e_pkg::TWO_PI24;
        else if (a < -rv2e_pkg::PI24) a = a + rv2e_pkg::TWO_PI24;
        flag_d = 1'b0;
        if (a > rv2e_pkg::HALF_PI24) begin
          a      = a - rv2e_pkg::PI24;
          flag_d = 1'b1;
        end else if (a < -rv2e_pkg::HALF_PI24) begin
          a      = a + rv2e_pkg::PI24;
          flag_d = 1'b1;
        end
        x_d = x_i;
        y_d = y_i;
        z_d = a;
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    xc[0] <= x_d;
    yc[0] <= y_d;
    zc[0] <= z_d;
    fc[0] <= flag_d;
  end

  generate
    for (genvar i = 0; i < STEPS; i++) begin : g_cell
      rv2e_cordic_cell #(.STEP(i), .VEC(VEC)) u_cell (
        .clk_i  (clk_i),
        .x_i    (xc[i]),
        .y_i    (yc[i]),
        .z_i    (zc[i]),
        .flag_i (fc[i]),
        .x_o    (xc[i+1]),
        .y_o    (yc[i+1]),
        .z_o    (zc[i+1]),
        .flag_o (fc[i+1])
      );
    end
  endgenerate

  generate
    if (VEC) begin : g_vec_post
      assign x_o = xc[STEPS];
      assign y_o = yc[STEPS];
      assign z_o = fc[STEPS] ? '0 : zc[STEPS];
    end else begin : g_rot_post
      assign x_o = fc[STEPS] ? -xc[STEPS] : xc[STEPS];
      assign y_o = fc[STEPS] ? -yc[STEPS] : yc[STEPS];
      assign z_o = zc[STEPS];
    end
  endgenerate

endmodule

`default_nettype wire

FILE: design/rv2e_div_cell.sv
// One restoring-division stage for three lanes sharing a divisor.
// Depends on rv2e_pkg for the lane struct and widths.
`default_nettype none

module rv2e_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                          clk_i,
  input  wire logic [rv2e_pkg::DEN_W-1:0]     den_i,
  input  wire rv2e_pkg::div_lane_t [2:0]      lane_i,
  output logic [rv2e_pkg::DEN_W-1:0]          den_o,
  output rv2e_pkg::div_lane_t [2:0]           lane_o
);

  rv2e_pkg::div_lane_t [2:0]    lane_d;
  logic [rv2e_pkg::REM_W-1:0]   r;

  always_comb begin
    lane_d = lane_i;
    r      = '0;
    for (int l = 0; l < 3; l++) begin
      r = {lane_i[l].rem[rv2e_pkg::REM_W-2:0], lane_i[l].num[BIT]};
      if (r >= {1'b0, den_i}) begin
        r                 = r - {1'b0, den_i};
        lane_d[l].q[BIT]  = 1'b1;
      end
      lane_d[l].rem = r;
    end
  end

  always_ff @(posedge clk_i) begin
    den_o  <= den_i;
    lane_o <= lane_d;
  end

endmodule

`default_nettype wire

FILE: design/rv2e_delay.sv
// Fixed-length shift line that keeps side data aligned with the CORDIC chains.
// No package dependency.
`default_nettype none

module rv2e_delay #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic [W-1:0]      q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

`default_nettype wire

FILE: design/rotation_vector_to_euler_core.sv
// Top level: rotation vector to Z-Y-X Euler angles through Rodrigues and CORDIC.
// Depends on rv2e_pkg, rv2e_cordic_chain, rv2e_div_cell and rv2e_delay.
//
//   channel   direction  signals                                  transaction when
//   command   in         start, busy, rot_x_i, rot_y_i, rot_z_i   start && !busy at clk_i rise
//   result    out        done_o, roll_o, pitch_o, yaw_o,          done_o high for one cycle
//                        gimbal_locked_o
//   config    in         cfg_we_i, cfg_wdata_i                    cfg_we_i at clk_i rise
//
// One transaction enters per clock; busy is never raised. The longest path from command
// to result holds four CORDIC chains of CORDIC_STEPS+1 stages each (magnitude, magnitude,
// then the sy/yaw chain and the pitch chain), plus the 28-stage axis divider that the
// Rodrigues angle chain overlaps.
// rst_ni clears the in-flight markers and loads the threshold register thr_q with 1; payload
// registers are not reset. The receiver cannot stall, so done_o is a pure strobe.
`default_nettype none

module rotation_vector_to_euler_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] rot_x_i,
  input  wire logic signed [15:0] rot_y_i,
  input  wire logic signed [15:0] rot_z_i,
  input  wire logic               cfg_we_i,
  input  wire logic [9:0]         cfg_wdata_i,
  output logic                    done_o,
  output logic signed [15:0]      roll_o,
  output logic signed [14:0]      pitch_o,
  output logic signed [15:0]      yaw_o,
  output logic                    gimbal_locked_o
);

  localparam int unsigned CW    = rv2e_pkg::CW;
  localparam int unsigned L     = CORDIC_STEPS + 1;     // register stages per CORDIC chain
  localparam int unsigned DB    = rv2e_pkg::DIV_BITS;
  localparam int unsigned VLD_N = 4 * L + 37;

  // 24-fraction-bit product, floor shift
  function automatic logic signed [CW-1:0] mul24(input logic signed [CW-1:0] a,
                                               input logic signed [28:0] b);
    logic signed [60:0] p;
    p = a * b;
    return p[55:24];
  endfunction

  function automatic logic signed [33:0] sum34(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return {{2{a[CW-1]}}, a} + {{2{b[CW-1]}}, b};
  endfunction

  function automatic logic signed [33:0] dif34(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return {{2{a[CW-1]}}, a} - {{2{b[CW-1]}}, b};
  endfunction

  logic                accept;
  logic [VLD_N-1:0]    vld_q;
  logic [9:0]          thr_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register and in-flight markers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 10'd1;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      vld_q <= {vld_q[VLD_N-2:0], accept};
    end
  end

  assign done_o = vld_q[VLD_N-1];

  // ---------------------------------------------------------------- input to Q.24
  logic signed [CW-1:0] rx_q, ry_q, rz_q;
  logic                 zero_q;

  always_ff @(posedge clk_i) begin
    rx_q   <= {{5{rot_x_i[15]}}, rot_x_i, 11'b0};
    ry_q   <= {{5{rot_y_i[15]}}, rot_y_i, 11'b0};
    rz_q   <= {{5{rot_z_i[15]}}, rot_z_i, 11'b0};
    zero_q <= (rot_x_i == '0) && (rot_y_i == '0) && (rot_z_i == '0);
  end

  // ---------------------------------------------------------------- theta = |r|
  logic signed [CW-1:0] c1_x, c2_x, m1_q, rz_d1;
  logic signed [CW-1:0] th_g;
  logic [rv2e_pkg::DEN_W-1:0] theta_q;

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b1)) u_mag_xy (
    .clk_i (clk_i), .x_i (rx_q), .y_i (ry_q), .z_i ('0),
    .x_o (c1_x), .y_o (), .z_o ()
  );

  rv2e_delay #(.W(CW), .DEPTH(L + 1)) u_dly_rz (
    .clk_i (clk_i), .d_i (rz_q), .q_o (rz_d1)
  );

  always_ff @(posedge clk_i) begin
    m1_q <= rv2e_pkg::gain_fn(c1_x);
  end

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b1)) u_mag_xyz (
    .clk_i (clk_i), .x_i (m1_q), .y_i (rz_d1), .z_i ('0),
    .x_o (c2_x), .y_o (), .z_o ()
  );

  // Hold theta at one or above so the divider never sees zero
  assign th_g = rv2e_pkg::gain_fn(c2_x);

  always_ff @(posedge clk_i) begin
    theta_q <= (th_g <= 0) ? rv2e_pkg::DEN_W'(1) : th_g[rv2e_pkg::DEN_W-1:0];
  end

  // ---------------------------------------------------------------- axis k = r / theta
  logic signed [CW-1:0] rx_d, ry_d, rz_d;
  logic [26:0]          ax, ay, az;
  logic [2:0]           sgn_d;
  rv2e_pkg::div_lane_t [2:0]  lane [DB+1];
  logic [rv2e_pkg::DEN_W-1:0] den  [DB+1];
  logic signed [28:0]   kx_q, ky_q, kz_q;

  rv2e_delay #(.W(3 * CW), .DEPTH(2 * L + 2)) u_dly_r (
    .clk_i (clk_i), .d_i ({rx_q, ry_q, rz_q}), .q_o ({rx_d, ry_d, rz_d})
  );

  assign ax = rx_d[CW-1] ? 27'(-rx_d) : rx_d[26:0];
  assign ay = ry_d[CW-1] ? 27'(-ry_d) : ry_d[26:0];
  assign az = rz_d[CW-1] ? 27'(-rz_d) : rz_d[26:0];

  assign den[0] = theta_q;
  assign lane[0][0] = '{rem: {6'b0, ax[26:4]}, num: {ax, 24'b0}, q: '0};
  assign lane[0][1] = '{rem: {6'b0, ay[26:4]}, num: {ay, 24'b0}, q: '0};
  assign lane[0][2] = '{rem: {6'b0, az[26:4]}, num: {az, 24'b0}, q: '0};

  generate
    for (genvar i = 0; i < DB; i++) begin : g_div
      rv2e_div_cell #(.BIT(DB - 1 - i)) u_div (
        .clk_i  (clk_i),
        .den_i  (den[i]),
        .lane_i (lane[i]),
        .den_o  (den[i+1]),
        .lane_o (lane[i+1])
      );
    end
  endgenerate

  rv2e_delay #(.W(3), .DEPTH(DB)) u_dly_sgn (
    .clk_i (clk_i), .d_i ({rx_d[CW-1], ry_d[CW-1], rz_d[CW-1]}), .q_o (sgn_d)
  );

  // Truncate toward zero: apply the sign to the magnitude quotient
  always_ff @(posedge clk_i) begin
    kx_q <= sgn_d[2] ? -$signed({1'b0, lane[DB][0].q}) : $signed({1'b0, lane[DB][0].q});
    ky_q <= sgn_d[1] ? -$signed({1'b0, lane[DB][1].q}) : $signed({1'b0, lane[DB][1].q});
    kz_q <= sgn_d[0] ? -$signed({1'b0, lane[DB][2].q}) : $signed({1'b0, lane[DB][2].q});
  end

  // ---------------------------------------------------------------- cos / sin theta
  logic signed [CW-1:0] c_r, s_r, c_d, s_d;

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b0)) u_rot (
    .clk_i (clk_i), .x_i (rv2e_pkg::KINV), .y_i ('0),
    .z_i ({{(CW - rv2e_pkg::DEN_W){1'b0}}, theta_q}),
    .x_o (c_r), .y_o (s_r), .z_o ()
  );

  rv2e_delay #(.W(2 * CW), .DEPTH(DB + 1 - L)) u_dly_cs (
    .clk_i (clk_i), .d_i ({c_r, s_r}), .q_o ({c_d, s_d})
  );

  // ---------------------------------------------------------------- Rodrigues matrix
  logic signed [CW-1:0] t_c;
  logic signed [CW-1:0] tx_q, ty_q, tz_q, skx_q, sky_q, skz_q, c1_q;
  logic signed [28:0]   kx1_q, ky1_q, kz1_q;
  logic signed [CW-1:0] a00_q, a10_q, a20_q, a11_q, a12_q, a22_q, c2_q;
  logic signed [CW-1:0] skx2_q, sky2_q, skz2_q;
  logic                 zero_d;
  logic signed [15:0]   r00_q, r10_q, r11_q, r21_q, r22_q, nr12_q, nr20_q;
  logic signed [15:0]   r12_c, r20_c;

  assign t_c = rv2e_pkg::ONE24 - c_d;

  always_ff @(posedge clk_i) begin
    tx_q  <= mul24(t_c, kx_q);
    ty_q  <= mul24(t_c, ky_q);
    tz_q  <= mul24(t_c, kz_q);
    skx_q <= mul24(s_d, kx_q);
    sky_q <= mul24(s_d, ky_q);
    skz_q <= mul24(s_d, kz_q);
    c1_q  <= c_d;
    kx1_q <= kx_q;
    ky1_q <= ky_q;
    kz1_q <= kz_q;
  end

  always_ff @(posedge clk_i) begin
    a00_q  <= mul24(tx_q, kx1_q);
    a10_q  <= mul24(tx_q, ky1_q);
    a20_q  <= mul24(tx_q, kz1_q);
    a11_q  <= mul24(ty_q, ky1_q);
    a12_q  <= mul24(ty_q, kz1_q);
    a22_q  <= mul24(tz_q, kz1_q);
    c2_q   <= c1_q;
    skx2_q <= skx_q;
    sky2_q <= sky_q;
    skz2_q <= skz_q;
  end

  rv2e_delay #(.W(1), .DEPTH(2 * L + 33)) u_dly_zero (
    .clk_i (clk_i), .d_i (zero_q), .q_o (zero_d)
  );

  assign r12_c = rv2e_pkg::to_q14(dif34(a12_q, skx2_q));
  assign r20_c = rv2e_pkg::to_q14(dif34(a20_q, sky2_q));

  // A zero rotation vector yields the identity matrix
  always_ff @(posedge clk_i) begin
    if (zero_d) begin
      r00_q  <= 16'sd16384;
      r11_q  <= 16'sd16384;
      r22_q  <= 16'sd16384;
      r10_q  <= '0;
      r21_q  <= '0;
      nr12_q <= '0;
      nr20_q <= '0;
    end else begin
      r00_q  <= rv2e_pkg::to_q14(sum34(c2_q, a00_q));
      r10_q  <= rv2e_pkg::to_q14(sum34(a10_q, skz2_q));
      r11_q  <= rv2e_pkg::to_q14(sum34(c2_q, a11_q));
      r21_q  <= rv2e_pkg::to_q14(sum34(a12_q, skx2_q));
      r22_q  <= rv2e_pkg::to_q14(sum34(c2_q, a22_q));
      nr12_q <= -r12_c;
      nr20_q <= -r20_c;
    end
  end

  // ---------------------------------------------------------------- sy, yaw, roll
  logic signed [CW-1:0] sy_x, yaw_z, rn_z, rl_z, sy_g, sy_r;
  logic signed [15:0]   nr20_d, roll_c, yaw_c;
  logic signed [16:0]   sy_c, sy_q;
  logic                 lock_c;
  logic signed [15:0]   roll_s_q, yaw_s_q;
  logic                 lock_s_q;

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b1)) u_vec_yaw (
    .clk_i (clk_i),
    .x_i ({{6{r00_q[15]}}, r00_q, 10'b0}), .y_i ({{6{r10_q[15]}}, r10_q, 10'b0}),
    .z_i ('0), .x_o (sy_x), .y_o (), .z_o (yaw_z)
  );

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b1)) u_vec_roll (
    .clk_i (clk_i),
    .x_i ({{6{r22_q[15]}}, r22_q, 10'b0}), .y_i ({{6{r21_q[15]}}, r21_q, 10'b0}),
    .z_i ('0), .x_o (), .y_o (), .z_o (rn_z)
  );

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b1)) u_vec_lock (
    .clk_i (clk_i),
    .x_i ({{6{r11_q[15]}}, r11_q, 10'b0}), .y_i ({{6{nr12_q[15]}}, nr12_q, 10'b0}),
    .z_i ('0), .x_o (), .y_o (), .z_o (rl_z)
  );

  rv2e_delay #(.W(16), .DEPTH(L + 1)) u_dly_r20 (
    .clk_i (clk_i), .d_i (nr20_q), .q_o (nr20_d)
  );

  // sy back to Q1.14 units, saturate at two
  always_comb begin
    sy_g = rv2e_pkg::gain_fn(sy_x);
    sy_r = (sy_g + 32'sd512) >>> 10;
    if (sy_r > rv2e_pkg::SY_LIM) sy_r = rv2e_pkg::SY_LIM;
    else if (sy_r < -rv2e_pkg::SY_LIM) sy_r = -rv2e_pkg::SY_LIM;
    sy_c   = sy_r[16:0];
    lock_c = sy_c < $signed({7'b0, thr_q});
    roll_c = rv2e_pkg::to_q13(lock_c ? rl_z : rn_z, rv2e_pkg::ANG_LIM);
    yaw_c  = lock_c ? '0 : rv2e_pkg::to_q13(yaw_z, rv2e_pkg::ANG_LIM);
  end

  always_ff @(posedge clk_i) begin
    sy_q     <= sy_c;
    lock_s_q <= lock_c;
    roll_s_q <= roll_c;
    yaw_s_q  <= yaw_c;
  end

  // ---------------------------------------------------------------- pitch
  logic signed [CW-1:0] pit_z;
  logic signed [15:0]   pitch_c, roll_d, yaw_d;
  logic                 lock_d;

  rv2e_cordic_chain #(.STEPS(CORDIC_STEPS), .VEC(1'b1)) u_vec_pitch (
    .clk_i (clk_i),
    .x_i ({{5{sy_q[16]}}, sy_q, 10'b0}), .y_i ({{6{nr20_d[15]}}, nr20_d, 10'b0}),
    .z_i ('0), .x_o (), .y_o (), .z_o (pit_z)
  );

  rv2e_delay #(.W(33), .DEPTH(L)) u_dly_out (
    .clk_i (clk_i), .d_i ({lock_s_q, roll_s_q, yaw_s_q}), .q_o ({lock_d, roll_d, yaw_d})
  );

  assign pitch_c = rv2e_pkg::to_q13(pit_z, rv2e_pkg::PITCH_LIM);

  always_ff @(posedge clk_i) begin
    roll_o          <= roll_d;
    yaw_o           <= yaw_d;
    gimbal_locked_o <= lock_d;
    pitch_o         <= pitch_c[14:0];
  end

  // ---------------------------------------------------------------- checks
  a_done_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, VLD_N))
    else $error("result without a matching command");

  a_cmd_gets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##VLD_N done_o)
    else $error("command dropped in the pipeline");

  a_lock_yaw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && gimbal_locked_o) |-> (yaw_o == '0))
    else $error("gimbal-locked result with nonzero yaw");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((pitch_o <= 15'sd12868) && (pitch_o >= -15'sd12868)))
    else $error("pitch outside plus or minus pi/2");

endmodule

`default_nettype wire
